// ----- rtl/slt_pkg.sv -----
package slt_pkg;

    localparam int unsigned ValueWidth = 32;
    localparam int unsigned CountWidth = 5;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t                          cmd;
        logic signed [ValueWidth-1:0]  value;
    } cmd_word_t;

    typedef struct packed {
        status_t                 status;
        logic                    found;
        logic [CountWidth-1:0]   count;
    } rsp_word_t;

    // Broadcast to every cell of the row in the cycle a command commits.
    typedef struct packed {
        logic                          ins;
        logic                          del;
        logic signed [ValueWidth-1:0]  value;
    } cell_ctrl_t;

endpackage

// ----- rtl/sorted_list_table.sv -----
// sorted_list_table: ascending table of signed 32-bit values, duplicates kept.
// Command channel (cmd_valid/cmd_stall/cmd_word) carries one word per command:
// insert, search, delete or clear, with the operand value. Response channel
// (rsp_valid/rsp_stall/rsp_word) returns one word per command with status,
// found flag and the number of entries held after the command.
// The table is a row of CAPACITY cells; every cell compares its entry with the
// operand in the same cycle and shifts left or right with its neighbors, so a
// command commits in the cycle it is accepted. The response is registered and
// valid in the cycle after accept; throughput is one command per cycle with
// no stall, set by the parallel compare and shift across the cell row.
// A response word sits in an output register; a new command is accepted while
// that register is empty or being drained in the same cycle. When the
// receiver stalls with a response waiting, cmd_stall rises and the table holds.
// Reset empties the table (fill count to zero) and drops any waiting response;
// cell contents are left as they are, since only the first fill cells are read.
module sorted_list_table #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  slt_pkg::cmd_word_t  cmd_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output slt_pkg::rsp_word_t  rsp_word
);

    localparam int unsigned FW = $clog2(CAPACITY + 1);

    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    slt_pkg::rsp_word_t rsp_word_reg;
    slt_pkg::rsp_word_t rsp_word_next;

    logic                                      accept;
    logic                                      full;
    logic                                      found;
    logic [FW+slt_pkg::CountWidth-1:0]         fill_wide;
    slt_pkg::cell_ctrl_t                       ctrl;

    logic signed [slt_pkg::ValueWidth-1:0]     cell_value [CAPACITY];
    logic [CAPACITY-1:0]                       cell_lt;
    logic [CAPACITY-1:0]                       cell_eq;
    logic [CAPACITY-1:0]                       cell_occupied;

    // Hold commands only while a response waits on a stalled receiver.
    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign full      = (fill_reg == FW'(CAPACITY));
    assign found     = |cell_eq;

    assign ctrl.ins   = accept && (cmd_word.cmd == slt_pkg::CMD_INSERT) && !full;
    assign ctrl.del   = accept && (cmd_word.cmd == slt_pkg::CMD_DELETE) && found;
    assign ctrl.value = cmd_word.value;

    // Cell row: each cell sees its neighbors' entries and the left compare.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                                  left_lt;
        logic signed [slt_pkg::ValueWidth-1:0] left_value;
        logic signed [slt_pkg::ValueWidth-1:0] right_value;

        assign cell_occupied[i] = (FW'(i) < fill_reg);

        if (i == 0)
        begin : g_first
            assign left_lt    = 1'b1;
            assign left_value = cmd_word.value;
        end
        else
        begin : g_inner
            assign left_lt    = cell_lt[i-1];
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_value = cell_value[i];
        end
        else
        begin : g_mid
            assign right_value = cell_value[i+1];
        end

        slt_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (cell_occupied[i]),
            .left_lt     (left_lt),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .lt          (cell_lt[i]),
            .eq          (cell_eq[i])
        );
    end

    always_comb
    begin
        fill_next      = fill_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_word_next  = rsp_word_reg;

        if (accept)
        begin
            rsp_valid_next       = 1'b1;
            rsp_word_next.status = slt_pkg::ST_DONE;
            rsp_word_next.found  = 1'b0;

            case (cmd_word.cmd)
                slt_pkg::CMD_INSERT:
                begin
                    if (full)
                    begin
                        rsp_word_next.status = slt_pkg::ST_FULL;
                    end
                    else
                    begin
                        fill_next = fill_reg + FW'(1);
                    end
                end
                slt_pkg::CMD_SEARCH:
                begin
                    rsp_word_next.found = found;
                end
                slt_pkg::CMD_DELETE:
                begin
                    if (found)
                    begin
                        rsp_word_next.found = 1'b1;
                        fill_next           = fill_reg - FW'(1);
                    end
                    else
                    begin
                        rsp_word_next.status = slt_pkg::ST_NOT_FOUND;
                    end
                end
                slt_pkg::CMD_CLEAR:
                begin
                    fill_next = '0;
                end
                default:
                begin
                    fill_next = fill_reg;
                end
            endcase
        end

        // count reports the fill modulo 32
        fill_wide           = {{slt_pkg::CountWidth{1'b0}}, fill_next};
        rsp_word_next.count = fill_wide[slt_pkg::CountWidth-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // Fill never passes the table size.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(CAPACITY))
        else $error("fill count above capacity");

    // An insert refused for a full table leaves the fill alone.
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd_word.cmd == slt_pkg::CMD_INSERT) && full |=> $stable(fill_reg))
        else $error("refused insert changed fill");

    // A successful delete drops exactly one entry.
    a_delete_one: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.del |=> fill_reg == $past(fill_reg) - FW'(1))
        else $error("delete did not remove one entry");

    // Held entries stay in ascending order across the cell row.
    for (genvar j = 0; j + 1 < CAPACITY; j++)
    begin : g_order_chk
        a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
            cell_occupied[j+1] |-> cell_value[j] <= cell_value[j+1])
            else $error("table out of order");
    end

endmodule

// ----- rtl/slt_cell.sv -----
module slt_cell (
    input  logic                                     clk,
    input  slt_pkg::cell_ctrl_t                      ctrl,
    input  logic                                     occupied,
    input  logic                                     left_lt,
    input  logic signed [slt_pkg::ValueWidth-1:0]    left_value,
    input  logic signed [slt_pkg::ValueWidth-1:0]    right_value,
    output logic signed [slt_pkg::ValueWidth-1:0]    value,
    output logic                                     lt,
    output logic                                     eq
);

    logic signed [slt_pkg::ValueWidth-1:0] value_reg;
    logic signed [slt_pkg::ValueWidth-1:0] value_next;

    // Only held entries take part in the compare.
    assign lt    = occupied && (value_reg < ctrl.value);
    assign eq    = occupied && (value_reg == ctrl.value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins && !lt)
        begin
            // first cell not below the operand takes it, the rest shift right
            value_next = left_lt ? ctrl.value : left_value;
        end
        else if (ctrl.del && !lt)
        begin
            // close the gap left by the first equal entry
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;

    localparam int unsigned Capacity   = 16;
    localparam int unsigned IdleLimit  = 2000;
    localparam int unsigned DrainCycles = 8;

    // Table model: predicts the response word for each accepted command
    // word and checks the response words in order.
    class table_scoreboard;
        logic signed [slt_pkg::ValueWidth-1:0] held[Capacity];
        int unsigned                           fill;
        slt_pkg::rsp_word_t                    rsp_q[$];
        int unsigned                           errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function int find_equal(logic signed [slt_pkg::ValueWidth-1:0] v);
            for (int i = 0; i < fill; i++)
                if (held[i] == v)
                    return i;
            return -1;
        endfunction

        // Apply one command word to the table and queue its response word.
        function void note_cmd(slt_pkg::cmd_word_t w);
            slt_pkg::rsp_word_t exp;
            int                 pos;
            exp.status = slt_pkg::ST_DONE;
            exp.found  = 1'b0;
            case (w.cmd)
                slt_pkg::CMD_INSERT:
                begin
                    if (fill >= Capacity)
                        exp.status = slt_pkg::ST_FULL;
                    else
                    begin
                        pos = 0;
                        while (pos < fill && held[pos] < w.value)
                            pos++;
                        for (int k = fill; k > pos; k--)
                            held[k] = held[k-1];
                        held[pos] = w.value;
                        fill++;
                    end
                end
                slt_pkg::CMD_SEARCH:
                    exp.found = (find_equal(w.value) >= 0);
                slt_pkg::CMD_DELETE:
                begin
                    pos = find_equal(w.value);
                    if (pos < 0)
                        exp.status = slt_pkg::ST_NOT_FOUND;
                    else
                    begin
                        exp.found = 1'b1;
                        for (int k = pos; k + 1 < fill; k++)
                            held[k] = held[k+1];
                        fill--;
                    end
                end
                default:
                    fill = 0;
            endcase
            exp.count = fill[slt_pkg::CountWidth-1:0];
            rsp_q.push_back(exp);
        endfunction

        function void check_rsp(slt_pkg::rsp_word_t got);
            slt_pkg::rsp_word_t exp;
            if (rsp_q.size() == 0)
            begin
                $display("%0t: response word with nothing pending: %s %0d found %0d count %0d",
                         $time, "status", got.status, got.found, got.count);
                errors++;
                return;
            end
            exp = rsp_q.pop_front();
            if (got.status !== exp.status)
            begin
                $display("%0t: status expected %0d got %0d", $time, exp.status, got.status);
                errors++;
            end
            if (got.found !== exp.found)
            begin
                $display("%0t: found expected %0d got %0d", $time, exp.found, got.found);
                errors++;
            end
            if (got.count !== exp.count)
            begin
                $display("%0t: count expected %0d got %0d", $time, exp.count, got.count);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return rsp_q.size();
        endfunction

        // Return a value currently held, to aim search and delete at hits.
        function logic signed [slt_pkg::ValueWidth-1:0] any_held();
            if (fill == 0)
                return '0;
            return held[$urandom_range(fill - 1)];
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    slt_pkg::cmd_word_t cmd_word  = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    slt_pkg::rsp_word_t rsp_word;

    int unsigned send_idle_pct = 0;
    int unsigned rsp_stall_pct = 0;
    int unsigned idle_cycles   = 0;

    table_scoreboard sb = new();

    sorted_list_table #(
        .CAPACITY (Capacity)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    always #5 clk = ~clk;

    // Receiver: stall at random at the rate of the current phase.
    always @(posedge clk)
        rsp_stall <= rst_n && ($urandom_range(99) < rsp_stall_pct);

    // Monitor: sample both handshakes at the edge, check responses before
    // noting the command of the same edge, and watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
                sb.check_rsp(rsp_word);
            if (cmd_valid === 1'b1 && cmd_stall === 1'b0)
                sb.note_cmd(cmd_word);
            if ((rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
                (cmd_valid === 1'b1 && cmd_stall === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit)
            begin
                $display("%0t: no word moved for %0d cycles", $time, IdleLimit);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Present one command word, idling first at the phase rate, and hold it
    // until the edge that accepts it.
    task automatic send_cmd(slt_pkg::cmd_t c, logic signed [slt_pkg::ValueWidth-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= '{cmd: c, value: v};
        @(posedge clk);
        while (cmd_stall !== 1'b0)
            @(posedge clk);
    endtask

    // Drop valid and hold off until every pending response has come back.
    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Operand mix: extremes and a small pool make duplicates, held values
    // make hits, the rest is full-range noise.
    function automatic logic signed [slt_pkg::ValueWidth-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return ($urandom_range(1)) ? 32'sh7fff_ffff : 32'sh8000_0000;
        if (r < 35)
            return $signed(32'($urandom_range(6))) - 32'sd3;
        if (r < 65)
            return sb.any_held();
        return $signed($urandom);
    endfunction

    function automatic slt_pkg::cmd_t pick_cmd();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45)
            return slt_pkg::CMD_INSERT;
        if (r < 70)
            return slt_pkg::CMD_SEARCH;
        if (r < 97)
            return slt_pkg::CMD_DELETE;
        return slt_pkg::CMD_CLEAR;
    endfunction

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-list search and delete, extremes, duplicates,
        // delete of the first of equals, fill to full, refused insert,
        // delete of an absent value, clear.
        send_cmd(slt_pkg::CMD_SEARCH, 32'sd5);
        send_cmd(slt_pkg::CMD_DELETE, 32'sd5);
        send_cmd(slt_pkg::CMD_INSERT, 32'sh7fff_ffff);
        send_cmd(slt_pkg::CMD_INSERT, 32'sh8000_0000);
        send_cmd(slt_pkg::CMD_INSERT, 32'sd0);
        send_cmd(slt_pkg::CMD_INSERT, 32'sd0);
        send_cmd(slt_pkg::CMD_SEARCH, 32'sh8000_0000);
        send_cmd(slt_pkg::CMD_SEARCH, 32'sh7fff_ffff);
        send_cmd(slt_pkg::CMD_DELETE, 32'sd0);
        send_cmd(slt_pkg::CMD_SEARCH, 32'sd0);
        for (int i = 0; i < 13; i++)
            send_cmd(slt_pkg::CMD_INSERT,
                     (i % 4 == 0) ? 32'sh8000_0000 : $signed($urandom));
        send_cmd(slt_pkg::CMD_INSERT, 32'sd1);
        send_cmd(slt_pkg::CMD_DELETE, 32'sd12345);
        send_cmd(slt_pkg::CMD_CLEAR, $signed($urandom));
        send_cmd(slt_pkg::CMD_DELETE, 32'sd0);

        // Random phases: none idle, sender idle, receiver stalling, both.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 62; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 62; end
                default: begin send_idle_pct = 20; rsp_stall_pct = 20; end
            endcase
            for (int n = 0; n < 150; n++)
            begin
                if (n == 75 && ph == 2)
                    drain();
                send_cmd(pick_cmd(), pick_value());
            end
        end

        drain();
        repeat (DrainCycles) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
